// ===== rtl/meter_frame_receiver_macros.svh =====
// Shared assertion macros for the meter frame receiver.
`ifndef METER_FRAME_RECEIVER_MACROS_SVH
`define METER_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFR_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("mfr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MFR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("mfr: next-cycle check failed");

`endif

// ===== rtl/mfr_pkg.sv =====
package mfr_pkg;

    localparam int ADDRESS_BYTES_DEF = 6;
    localparam int ADDR_W            = 48;
    localparam int ADDR_KEPT         = ADDR_W / 8;
    localparam int FIXED_BYTES       = 2;

    localparam logic [7:0] START_MARKER_RST = 8'h68;
    localparam logic [7:0] END_MARKER_RST   = 8'h16;

    // configuration register indexes
    localparam logic CFG_START_MARKER = 1'b0;
    localparam logic CFG_END_MARKER   = 1'b1;

    // parser phases
    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_ADDR    = 3'd1;
    localparam logic [2:0] PH_FIXED   = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CSUM    = 3'd5;
    localparam logic [2:0] PH_STOP    = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
    localparam logic [1:0] STATUS_BAD_STOP = 2'd2;

    typedef struct packed {
        logic              has_result;
        logic              kind;
        logic [7:0]        payload_byte;
        logic [7:0]        payload_index;
        logic [7:0]        payload_length;
        logic [ADDR_W-1:0] meter_address;
        logic [1:0]        frame_status;
    } mfr_result_t;

endpackage

// ===== rtl/mfr_parser.sv =====
`include "meter_frame_receiver_macros.svh"

module mfr_parser
    import mfr_pkg::*;
#(
    parameter int ADDRESS_BYTES = ADDRESS_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    input  logic        reply_expected,
    input  logic [7:0]  start_marker,
    input  logic [7:0]  end_marker,
    output mfr_result_t result
);

    localparam int CNT_MAX = (ADDRESS_BYTES > FIXED_BYTES) ? ADDRESS_BYTES : FIXED_BYTES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    logic [2:0]        phase_reg,     phase_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [7:0]        sum_reg,       sum_next;
    logic [ADDR_W-1:0] addr_reg,      addr_next;
    logic [7:0]        length_reg,    length_next;
    logic [7:0]        remain_reg,    remain_next;
    logic              matched_reg,   matched_next;
    logic [CNT_W-1:0]  count_inc;
    logic [7:0]        remain_dec;

    assign count_inc  = count_reg + CNT_W'(1);
    assign remain_dec = remain_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        addr_next    = addr_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        matched_next = matched_reg;

        result                = '0;
        result.payload_length = length_reg;
        result.meter_address  = addr_reg;

        if (mode)
        begin
            // abort: drop the frame in progress
            phase_next   = PH_WAIT;
            count_next   = '0;
            sum_next     = '0;
            addr_next    = '0;
            length_next  = '0;
            remain_next  = '0;
            matched_next = 1'b0;
        end
        else if (reply_expected)
        begin
            case (phase_reg)
                PH_ADDR:
                begin
                    sum_next = sum_reg + rx_byte;
                    for (int i = 0; i < ADDR_KEPT; i++)
                    begin
                        if (int'(count_reg) == i)
                        begin
                            addr_next[8*i +: 8] = rx_byte;
                        end
                    end
                    count_next = count_inc;
                    if (count_inc == CNT_W'(ADDRESS_BYTES))
                    begin
                        count_next = '0;
                        phase_next = PH_FIXED;
                    end
                end
                PH_FIXED:
                begin
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_inc;
                    if (count_inc == CNT_W'(FIXED_BYTES))
                    begin
                        count_next = '0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    sum_next    = sum_reg + rx_byte;
                    length_next = rx_byte;
                    remain_next = rx_byte;
                    phase_next  = (rx_byte == 8'd0) ? PH_CSUM : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    sum_next             = sum_reg + rx_byte;
                    result.has_result    = 1'b1;
                    result.kind          = KIND_PAYLOAD;
                    result.payload_byte  = rx_byte;
                    result.payload_index = length_reg - remain_reg;
                    remain_next          = remain_dec;
                    if (remain_dec == 8'd0)
                    begin
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                    matched_next = (sum_reg == rx_byte);
                    phase_next   = PH_STOP;
                end
                PH_STOP:
                begin
                    result.has_result = 1'b1;
                    result.kind       = KIND_STATUS;
                    if (!matched_reg)
                    begin
                        result.frame_status = STATUS_BAD_SUM;
                    end
                    else if (rx_byte != end_marker)
                    begin
                        result.frame_status = STATUS_BAD_STOP;
                    end
                    else
                    begin
                        result.frame_status = STATUS_OK;
                    end
                    phase_next   = PH_WAIT;
                    count_next   = '0;
                    sum_next     = '0;
                    addr_next    = '0;
                    length_next  = '0;
                    remain_next  = '0;
                    matched_next = 1'b0;
                end
                default:
                begin
                    if (rx_byte == start_marker)
                    begin
                        phase_next   = PH_ADDR;
                        count_next   = '0;
                        sum_next     = rx_byte;
                        addr_next    = '0;
                        length_next  = '0;
                        remain_next  = '0;
                        matched_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            count_reg   <= '0;
            sum_reg     <= '0;
            addr_reg    <= '0;
            length_reg  <= '0;
            remain_reg  <= '0;
            matched_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            addr_reg    <= addr_next;
            length_reg  <= length_next;
            remain_reg  <= remain_next;
            matched_reg <= matched_next;
        end
    end

    // payload phase always has bytes left to take
    `MFR_ASSERT_NOW(a_payload_left, clk, rst_n, phase_reg == PH_PAYLOAD, remain_reg != 8'd0)
    // address count stays inside the address field
    `MFR_ASSERT_NOW(a_addr_count, clk, rst_n, phase_reg == PH_ADDR, int'(count_reg) < ADDRESS_BYTES)
    // an abort always lands in the wait phase with a clean sum
    `MFR_ASSERT_NEXT(a_abort_idle, clk, rst_n, fire && mode, phase_reg == PH_WAIT && sum_reg == 8'd0)
    // the stop byte closes the frame and reports status
    `MFR_ASSERT_NEXT(a_stop_close, clk, rst_n,
        fire && !mode && reply_expected && phase_reg == PH_STOP,
        phase_reg == PH_WAIT && addr_reg == '0)

endmodule

// ===== rtl/meter_frame_receiver.sv =====
// Meter reply frame receiver. Takes one beat per cycle: a received byte, an
// abort (mode 1, e.g. on a line timeout) or a byte that is dropped because no
// reply is expected. Frames are start marker, the address bytes, two fixed
// bytes, a length byte, the payload, a mod-256 sum over all earlier bytes and
// a stop marker. Each payload byte comes out as a kind 0 beat with its index;
// the stop byte yields one kind 1 beat with the address and the status (bad
// checksum wins over a bad stop marker). Sustained rate is one input beat per
// clock while out_ready keeps the result slot free. An accepted beat lands in
// the input register; the per-byte parser update sits between it and the
// result register, which drives out_valid. A result held by a low out_ready
// stalls the input once the input register is also full. Start and end
// markers are written through the cfg port (index 0 start, 1 end); the user
// must do so only while the block is idle, which the block does not enforce.
module meter_frame_receiver
    import mfr_pkg::*;
#(
    parameter int ADDRESS_BYTES = ADDRESS_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [7:0]        rx_byte,
    input  logic              reply_expected,

    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic [7:0]        payload_byte,
    output logic [7:0]        payload_index,
    output logic [7:0]        payload_length,
    output logic [ADDR_W-1:0] meter_address,
    output logic [1:0]        frame_status,

    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);

    // config registers
    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;

    // input register stage
    logic       in_vld_reg;
    logic       mode_reg;
    logic [7:0] rx_byte_reg;
    logic       reply_reg;

    // result register stage
    logic              out_vld_reg;
    logic              kind_reg;
    logic [7:0]        pbyte_reg;
    logic [7:0]        pindex_reg;
    logic [7:0]        plength_reg;
    logic [ADDR_W-1:0] addr_out_reg;
    logic [1:0]        status_reg;

    logic        out_free;
    logic        fire;
    mfr_result_t result;

    // The held beat is parsed when the result slot can take whatever it
    // produces; beats without a result just pass through the parser.
    assign out_free = !out_vld_reg || out_ready;
    assign fire     = in_vld_reg && out_free;
    assign in_ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_data;
                CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                default:          start_marker_reg <= start_marker_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg    <= mode;
            rx_byte_reg <= rx_byte;
            reply_reg   <= reply_expected;
        end
    end

    mfr_parser #(
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .mode           (mode_reg),
        .rx_byte        (rx_byte_reg),
        .reply_expected (reply_reg),
        .start_marker   (start_marker_reg),
        .end_marker     (end_marker_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= fire && result.has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && result.has_result)
        begin
            kind_reg     <= result.kind;
            pbyte_reg    <= result.payload_byte;
            pindex_reg   <= result.payload_index;
            plength_reg  <= result.payload_length;
            addr_out_reg <= result.meter_address;
            status_reg   <= result.frame_status;
        end
    end

    assign out_valid      = out_vld_reg;
    assign kind           = kind_reg;
    assign payload_byte   = pbyte_reg;
    assign payload_index  = pindex_reg;
    assign payload_length = plength_reg;
    assign meter_address  = addr_out_reg;
    assign frame_status   = status_reg;

endmodule

// ===== verif/meter_frame_receiver_test.sv =====
`timescale 1ns / 100ps

module meter_frame_receiver_test;
    import mfr_pkg::*;

    localparam int SETTLE_CYCLES = 8;      // pipeline is two deep, leave margin
    localparam int LONG_HOLD     = 300;    // output hold-off that backs up the input
    localparam int DRAIN_LIMIT   = 100000;

    // one input beat as the driver offers it
    typedef struct packed {
        logic       mode;
        logic [7:0] value;
        logic       reply;
    } rx_item_t;

    // one output beat as the block should give it
    typedef struct packed {
        logic              kind;
        logic [7:0]        data;
        logic [7:0]        index;
        logic [7:0]        length;
        logic [ADDR_W-1:0] address;
        logic [1:0]        status;
    } frame_beat_t;

    logic clk;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    logic mode = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic reply_expected = 1'b0;

    logic out_valid;
    logic out_ready = 1'b0;
    logic kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] payload_length;
    logic [ADDR_W-1:0] meter_address;
    logic [1:0] frame_status;

    logic cfg_we = 1'b0;
    logic cfg_index = CFG_START_MARKER;
    logic [7:0] cfg_data = 8'h00;

    meter_frame_receiver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .rx_byte        (rx_byte),
        .reply_expected (reply_expected),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .payload_index  (payload_index),
        .payload_length (payload_length),
        .meter_address  (meter_address),
        .frame_status   (frame_status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // stimulus still to be offered, and beats the block still owes us
    rx_item_t    pending_rx[$];
    frame_beat_t expected_beats[$];

    // marker registers as the block should hold them
    logic [7:0] cur_start = START_MARKER_RST;
    logic [7:0] cur_end   = END_MARKER_RST;

    // parser image, mirrors the block's frame state
    logic [2:0]        prs_phase = PH_WAIT;
    logic [3:0]        prs_count = '0;
    logic [7:0]        prs_sum   = '0;
    logic [ADDR_W-1:0] prs_addr  = '0;
    logic [7:0]        prs_len   = '0;
    logic [7:0]        prs_left  = '0;
    logic              prs_sum_ok = 1'b0;

    bit idle_en = 1'b1;        // random gaps on both sides
    int hold_requests = 0;     // bumped by the sequencer, served by the monitor
    int items_queued = 0;
    int beats_in = 0;
    int beats_out = 0;
    int frame_ends = 0;
    int field_mismatches = 0;
    int unexpected_beats = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // parser image
    // ---------------------------------------------------------------
    function automatic void clear_frame_state();
        prs_phase  = PH_WAIT;
        prs_count  = '0;
        prs_sum    = '0;
        prs_addr   = '0;
        prs_len    = '0;
        prs_left   = '0;
        prs_sum_ok = 1'b0;
    endfunction

    // advance the parser image by one accepted beat; returns 1 when a
    // result beat is due, with its contents in r
    function automatic bit parse_rx_beat(input rx_item_t it, output frame_beat_t r);
        logic [7:0] b;
        bit         due;
        b   = it.value;
        due = 1'b0;
        r   = '0;
        // abort wins over everything, even with no reply outstanding
        if (it.mode) begin
            clear_frame_state();
            return 1'b0;
        end
        if (!it.reply)
            return 1'b0;
        case (prs_phase)
            PH_ADDR: begin
                prs_sum = prs_sum + b;
                if (int'(prs_count) < ADDR_KEPT)
                    prs_addr[int'(prs_count) * 8 +: 8] = b;
                prs_count = prs_count + 4'd1;
                if (int'(prs_count) >= ADDRESS_BYTES_DEF) begin
                    prs_count = '0;
                    prs_phase = PH_FIXED;
                end
            end
            PH_FIXED: begin
                prs_sum   = prs_sum + b;
                prs_count = prs_count + 4'd1;
                if (int'(prs_count) >= FIXED_BYTES) begin
                    prs_count = '0;
                    prs_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                prs_sum   = prs_sum + b;
                prs_len   = b;
                prs_left  = b;
                prs_phase = (b == 8'd0) ? PH_CSUM : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                prs_sum   = prs_sum + b;
                r.kind    = KIND_PAYLOAD;
                r.data    = b;
                r.index   = prs_len - prs_left;
                r.length  = prs_len;
                r.address = prs_addr;
                r.status  = STATUS_OK;
                due       = 1'b1;
                prs_left  = prs_left - 8'd1;
                if (prs_left == 8'd0)
                    prs_phase = PH_CSUM;
            end
            PH_CSUM: begin
                prs_sum_ok = (prs_sum == b);
                prs_phase  = PH_STOP;
            end
            PH_STOP: begin
                r.kind    = KIND_STATUS;
                r.length  = prs_len;
                r.address = prs_addr;
                // checksum fault is seen first and wins
                if (!prs_sum_ok)
                    r.status = STATUS_BAD_SUM;
                else if (b != cur_end)
                    r.status = STATUS_BAD_STOP;
                else
                    r.status = STATUS_OK;
                due = 1'b1;
                clear_frame_state();
            end
            default: begin
                if (b == cur_start) begin
                    clear_frame_state();
                    prs_sum   = b;
                    prs_phase = PH_ADDR;
                end
            end
        endcase
        return due;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // driver: offers pending_rx, predicts on each accepted beat
    // ---------------------------------------------------------------
    rx_item_t drv_item = '0;
    int       drv_gap  = 0;

    always @(posedge clk or negedge rst_n) begin
        frame_beat_t due_beat;
        if (!rst_n) begin
            in_valid       <= 1'b0;
            mode           <= 1'b0;
            rx_byte        <= 8'h00;
            reply_expected <= 1'b0;
            drv_gap = 0;
        end
        else begin
            if (in_valid && in_ready) begin
                if (parse_rx_beat(drv_item, due_beat))
                    expected_beats.push_back(due_beat);
                beats_in++;
            end
            // free to change the payload only when nothing is held
            if (!in_valid || in_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_rx.size() > 0) begin
                    drv_item = pending_rx.pop_front();
                    mode           <= drv_item.mode;
                    rx_byte        <= drv_item.value;
                    reply_expected <= drv_item.reply;
                    in_valid       <= 1'b1;
                    drv_gap = pick_gap();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks each accepted output beat, drives out_ready
    // ---------------------------------------------------------------
    int mon_stall = 0;
    int mon_hold  = 0;
    int holds_seen = 0;

    function automatic void check_field(input string name, input logic [ADDR_W-1:0] want,
                                        input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            field_mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        frame_beat_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            mon_stall = 0;
            mon_hold  = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                beats_out++;
                if (kind === KIND_STATUS)
                    frame_ends++;
                if (expected_beats.size() == 0) begin
                    $error("output beat with nothing expected: kind %0h", kind);
                    unexpected_beats++;
                end
                else begin
                    want = expected_beats.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("payload_byte", want.data, payload_byte);
                    check_field("payload_index", want.index, payload_index);
                    check_field("payload_length", want.length, payload_length);
                    check_field("meter_address", want.address, meter_address);
                    check_field("frame_status", want.status, frame_status);
                end
            end
            // long hold-off on request, else short random stalls
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                mon_hold   = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (mon_hold > 0) begin
                mon_hold--;
                out_ready <= 1'b0;
            end
            else if (mon_stall > 0) begin
                mon_stall--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                if (idle_en && $urandom_range(0, 9) == 0)
                    mon_stall = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------
    task automatic queue_beat(input logic m, input logic [7:0] b, input logic re);
        rx_item_t it;
        it.mode  = m;
        it.value = b;
        it.reply = re;
        pending_rx.push_back(it);
        if (m || re)
            items_queued++;
    endtask

    // frame byte, sometimes preceded by a byte dropped for no reply outstanding
    task automatic queue_rx(input logic [7:0] b, input int drop_pct);
        if ($urandom_range(0, 99) < drop_pct)
            queue_beat(1'b0, 8'($urandom), 1'b0);
        queue_beat(1'b0, b, 1'b1);
    endtask

    task automatic queue_frame(input int len, input bit bad_sum, input bit bad_stop,
                               input int drop_pct);
        logic [7:0] sum;
        logic [7:0] b;
        sum = cur_start;
        queue_rx(cur_start, drop_pct);
        repeat (ADDRESS_BYTES_DEF + FIXED_BYTES) begin
            b = 8'($urandom);
            sum = sum + b;
            queue_rx(b, drop_pct);
        end
        b = 8'(len);
        sum = sum + b;
        queue_rx(b, drop_pct);
        repeat (len) begin
            b = 8'($urandom);
            sum = sum + b;
            queue_rx(b, drop_pct);
        end
        b = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
        queue_rx(b, drop_pct);
        b = bad_stop ? cur_end + 8'($urandom_range(1, 255)) : cur_end;
        queue_rx(b, drop_pct);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 85)
            return $urandom_range(1, 8);
        return $urandom_range(9, 40);
    endfunction

    task automatic queue_directed();
        logic [7:0] sum;
        logic [7:0] hdr[10];
        // stray bytes while idle, one of them a start marker with no reply pending
        queue_beat(1'b0, 8'h00, 1'b1);
        queue_beat(1'b0, cur_start, 1'b0);
        // frame cut short by an abort that arrives with no reply pending
        queue_beat(1'b0, cur_start, 1'b1);
        queue_beat(1'b0, 8'hFF, 1'b1);
        queue_beat(1'b0, 8'h00, 1'b1);
        queue_beat(1'b1, 8'hFF, 1'b0);
        // empty payload, wrong checksum and wrong stop, a dropped byte inside
        hdr = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hFF, 8'h00, 8'h00, 8'h00};
        sum = cur_start;
        queue_beat(1'b0, cur_start, 1'b1);
        for (int i = 0; i < 9; i++) begin
            if (i == 8)
                queue_beat(1'b0, 8'hA5, 1'b0);
            sum = sum + hdr[i];
            queue_beat(1'b0, hdr[i], 1'b1);
        end
        queue_beat(1'b0, sum ^ 8'hFF, 1'b1);
        queue_beat(1'b0, ~cur_end, 1'b1);
    endtask

    // mostly well-formed frames, plus broken ones, noise and lone aborts
    task automatic queue_random(input int n);
        int target;
        int pick;
        logic [7:0] b;
        target = items_queued + n;
        while (items_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_frame(pick_len(), $urandom_range(0, 99) < 12,
                            $urandom_range(0, 99) < 12,
                            ($urandom_range(0, 1) == 1) ? 5 : 0);
            end
            else if (pick < 85) begin
                queue_beat(1'b0, cur_start, 1'b1);
                repeat ($urandom_range(0, 14))
                    queue_beat(1'b0, 8'($urandom), 1'b1);
                queue_beat(1'b1, 8'($urandom), 1'($urandom));
            end
            else if (pick < 95) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1) == 1) begin
                        queue_beat(1'b0, 8'($urandom), 1'b0);
                    end
                    else begin
                        b = 8'($urandom);
                        if (b == cur_start)
                            b = b ^ 8'h01;
                        queue_beat(1'b0, b, 1'b1);
                    end
                end
            end
            else begin
                queue_beat(1'b1, 8'($urandom), 1'($urandom));
            end
        end
    endtask

    // sender has nothing left and every owed beat has come back
    task automatic wait_idle();
        int n;
        n = 0;
        @(negedge clk);
        while ((pending_rx.size() != 0 || in_valid || expected_beats.size() != 0)
               && n < DRAIN_LIMIT) begin
            @(negedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_marker(input logic idx, input logic [7:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_MARKER)
            cur_start = v;
        else
            cur_end = v;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    initial begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset markers, directed corner frames
        idle_en = 1'b1;
        queue_directed();
        wait_idle();

        // reset markers, random traffic with one long output hold
        queue_random(180);
        hold_requests++;
        wait_idle();

        // all-zero start, all-ones stop, back to back with no gaps
        write_marker(CFG_START_MARKER, 8'h00);
        write_marker(CFG_END_MARKER, 8'hFF);
        idle_en = 1'b0;
        queue_random(180);
        wait_idle();

        // all-ones start, all-zero stop, including a full 255 byte payload
        write_marker(CFG_START_MARKER, 8'hFF);
        write_marker(CFG_END_MARKER, 8'h00);
        idle_en = 1'b1;
        queue_frame(255, 1'b0, 1'b0, 0);
        queue_random(80);
        wait_idle();

        // random markers
        write_marker(CFG_START_MARKER, 8'($urandom));
        write_marker(CFG_END_MARKER, 8'($urandom));
        queue_random(150);
        wait_idle();

        if (expected_beats.size() != 0)
            $error("%0d output beats never arrived", expected_beats.size());

        $display("Covered %0d input beats and %0d output beats, %0d of them frame ends,",
                 beats_in, beats_out, frame_ends);
        $display("over reset, extreme and random marker values with stalls and a long hold");
        if (field_mismatches == 0 && unexpected_beats == 0 && expected_beats.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
